### design/float_natural_log_pade_unit_macros.svh
`ifndef FLOAT_NATURAL_LOG_PADE_UNIT_MACROS_SVH
`define FLOAT_NATURAL_LOG_PADE_UNIT_MACROS_SVH

// Implication checked in the same cycle, off while reset is asserted.
`define FNLP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fnlp checker: same-cycle implication failed");

// Implication checked in the next cycle, off while reset is asserted.
`define FNLP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fnlp checker: next-cycle implication failed");

// Implication checked in the next cycle, also while reset is asserted.
`define FNLP_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fnlp checker: reset-time implication failed");

`endif

### design/fnlp_pkg.sv
`default_nettype none

package fnlp_pkg;

    localparam int MANT_BITS         = 23;
    localparam int EXP_BITS          = 8;
    localparam int EXP_BIAS          = 127;
    localparam int SIG_W             = MANT_BITS + 1;
    localparam int SQ_W              = 2 * SIG_W;
    localparam int DIV_W             = SQ_W + 2;
    localparam int QUOT_W            = 32;
    localparam int SUM_W             = 41;
    localparam int OUT_W             = 32;
    localparam int EXP_UNB_W         = EXP_BITS + 2;
    localparam int FRAC_BITS_DEFAULT = 24;

    // ln(2) scaled by 2^32, rounded to nearest.
    localparam logic [QUOT_W-1:0] LN2_Q32 = 32'hB17217F8;

    // Sideband that travels with each item through the divider.
    typedef struct packed {
        logic                    invalid;
        logic signed [SUM_W-1:0] eln2;
    } fnlp_side_t;

endpackage

`default_nettype wire

### design/float_natural_log_pade_unit.sv
// Pipeline: decode and square, numerator and denominator, 32 one-bit divider
// stages, round and output; each stage is registered.
// Throughput: one operand per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken.
// Reset: synchronous, active low on aresetn; it clears all valid bits only.
`default_nettype none

module float_natural_log_pade_unit
    import fnlp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [31:0]             s_x_bits,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [OUT_W-1:0]      m_log_value,
    output logic                         m_invalid
);

    localparam int SHIFT = QUOT_W - FRAC_BITS;
    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        SUM_W'(1) <<< (SHIFT - 1);

    logic en;

    // Stage 1: field decode, square of the significand, exponent times ln2.
    logic                        in_sign;
    logic [EXP_BITS-1:0]         in_expf;
    logic [MANT_BITS-1:0]        in_frac;
    logic                        in_invalid;
    logic [SIG_W-1:0]            in_sig;
    logic signed [EXP_UNB_W-1:0] in_exp_unb;
    logic [SQ_W-1:0]             sq_next;
    logic signed [SUM_W-1:0]     eln2_next;

    logic                        s1_valid_reg;
    logic                        s1_invalid_reg;
    logic [SIG_W-1:0]            s1_sig_reg;
    logic [SQ_W-1:0]             s1_sq_reg;
    logic signed [SUM_W-1:0]     s1_eln2_reg;

    always_comb begin
        in_sign    = s_x_bits[31];
        in_expf    = s_x_bits[30:23];
        in_frac    = s_x_bits[MANT_BITS-1:0];
        // A NaN is never flagged, whatever its sign.
        in_invalid = (in_sign && !((&in_expf) && (|in_frac)))
                     || (s_x_bits[30:0] == '0);
        in_sig     = {1'b1, in_frac};
        in_exp_unb = $signed({2'b00, in_expf}) - EXP_UNB_W'(EXP_BIAS);
        sq_next    = SQ_W'(in_sig) * SQ_W'(in_sig);
        eln2_next  = SUM_W'(in_exp_unb) * $signed({1'b0, LN2_Q32});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_invalid_reg <= in_invalid;
            s1_sig_reg     <= in_sig;
            s1_sq_reg      <= sq_next;
            s1_eln2_reg    <= eln2_next;
        end
    end

    // Stage 2: numerator 3(M^2 - 2^46) and denominator M^2 + 2^25 M + 2^46.
    logic [DIV_W-1:0] sq_off;
    logic [DIV_W-1:0] num_next;
    logic [DIV_W-1:0] den_next;
    fnlp_side_t       side_next;

    logic             s2_valid_reg;
    logic [DIV_W-1:0] s2_num_reg;
    logic [DIV_W-1:0] s2_den_reg;
    fnlp_side_t       s2_side_reg;

    always_comb begin
        sq_off    = DIV_W'(s1_sq_reg) - (DIV_W'(1) << (2 * MANT_BITS));
        num_next  = (sq_off << 1) + sq_off;
        den_next  = DIV_W'(s1_sq_reg) + (DIV_W'(s1_sig_reg) << (MANT_BITS + 2))
                    + (DIV_W'(1) << (2 * MANT_BITS));
        // The rounding half is folded in here to keep the last stage short.
        side_next.invalid = s1_invalid_reg;
        side_next.eln2    = s1_eln2_reg + ROUND_HALF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_num_reg  <= num_next;
            s2_den_reg  <= den_next;
            s2_side_reg <= side_next;
        end
    end

    // Divider stages.
    logic              div_valid;
    logic [QUOT_W-1:0] div_quot;
    fnlp_side_t        div_side;

    fnlp_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_num    (s2_num_reg),
        .in_den    (s2_den_reg),
        .in_side   (s2_side_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // Final stage: add the exponent term, floor to FRAC_BITS, register.
    logic signed [SUM_W-1:0] sum_full;
    logic signed [SUM_W-1:0] sum_round;
    logic signed [OUT_W-1:0] log_next;

    logic                    m_valid_reg;
    logic signed [OUT_W-1:0] m_log_value_reg;
    logic                    m_invalid_reg;

    always_comb begin
        sum_full  = $signed({{(SUM_W - QUOT_W){1'b0}}, div_quot}) + div_side.eln2;
        sum_round = sum_full >>> SHIFT;
        log_next  = div_side.invalid ? '0 : sum_round[OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_log_value_reg <= log_next;
            m_invalid_reg   <= div_side.invalid;
        end
    end

    assign en          = !m_valid_reg || m_ready;
    assign s_ready     = aresetn && en;
    assign m_valid     = m_valid_reg;
    assign m_log_value = m_log_value_reg;
    assign m_invalid   = m_invalid_reg;

endmodule

`default_nettype wire

### design/fnlp_div_pipe.sv
`default_nettype none

module fnlp_div_pipe
    import fnlp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [DIV_W-1:0]  in_num,
    input  wire logic [DIV_W-1:0]  in_den,
    input  wire fnlp_side_t        in_side,
    output logic                   out_valid,
    output logic [QUOT_W-1:0]      out_quot,
    output fnlp_side_t             out_side
);

    // One restoring division step per stage; the quotient is below one, so the
    // remainder always stays below the divisor.
    logic              vld_reg  [QUOT_W];
    logic [QUOT_W-1:0] quot_reg [QUOT_W];
    fnlp_side_t        side_reg [QUOT_W];
    logic [DIV_W-1:0]  rem_reg  [QUOT_W-1];
    logic [DIV_W-1:0]  den_reg  [QUOT_W-1];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        logic              prev_vld;
        logic [DIV_W-1:0]  prev_rem;
        logic [DIV_W-1:0]  prev_den;
        logic [QUOT_W-1:0] prev_quot;
        fnlp_side_t        prev_side;
        logic [DIV_W:0]    rem_sh;
        logic [DIV_W:0]    rem_diff;
        logic              take;
        logic [DIV_W-1:0]  rem_next;
        logic [QUOT_W-1:0] quot_next;

        if (k == 0) begin : g_first
            assign prev_vld  = in_valid;
            assign prev_rem  = in_num;
            assign prev_den  = in_den;
            assign prev_quot = '0;
            assign prev_side = in_side;
        end else begin : g_rest
            assign prev_vld  = vld_reg[k-1];
            assign prev_rem  = rem_reg[k-1];
            assign prev_den  = den_reg[k-1];
            assign prev_quot = quot_reg[k-1];
            assign prev_side = side_reg[k-1];
        end

        always_comb begin
            rem_sh    = {prev_rem, 1'b0};
            rem_diff  = rem_sh - {1'b0, prev_den};
            take      = (rem_sh >= {1'b0, prev_den});
            rem_next  = take ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            quot_next = {prev_quot[QUOT_W-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= prev_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quot_reg[k] <= quot_next;
                side_reg[k] <= prev_side;
            end
        end

        if (k < QUOT_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= prev_den;
                end
            end
        end
    end

    assign out_valid = vld_reg[QUOT_W-1];
    assign out_quot  = quot_reg[QUOT_W-1];
    assign out_side  = side_reg[QUOT_W-1];

endmodule

`default_nettype wire

### design/fnlp_checker.sv
`default_nettype none

`include "float_natural_log_pade_unit_macros.svh"

module fnlp_checker
    import fnlp_pkg::*;
(
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_ready,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic signed [OUT_W-1:0] m_log_value,
    input wire logic                    m_invalid
);

    // A flagged result always carries a zero value.
    `FNLP_ASSERT_IMPL(a_invalid_zero, aclk, aresetn, m_valid && m_invalid, m_log_value == '0)

    // A held result stalls the whole pipeline, so no transfer enters.
    `FNLP_ASSERT_IMPL(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready)

    // An empty or draining output never blocks the input side once out of reset.
    `FNLP_ASSERT_IMPL(a_free_when_draining, aclk, aresetn, aresetn && (!m_valid || m_ready), s_ready)

    // Reset empties the output register.
    `FNLP_ASSERT_ALWAYS_NEXT(a_reset_clears, aclk, !aresetn, !m_valid)

endmodule

bind float_natural_log_pade_unit fnlp_checker u_fnlp_checker (.*);

`default_nettype wire

### test/float_natural_log_pade_unit_tb.sv
`default_nettype none

module float_natural_log_pade_unit_tb
    import fnlp_pkg::*;
;

    localparam int FRAC_BITS     = FRAC_BITS_DEFAULT;
    localparam int RANDOM_ITEMS  = 1530;
    localparam int SETTLE_CYCLES = 60;
    localparam int IDLE_LIMIT    = 4000;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    invalid;
    } log_result_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [31:0]             s_x_bits = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_log_value;
    logic                    m_invalid;

    logic [31:0] operand_q[$];
    log_result_t log_expect_q[$];
    int          fail_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    float_natural_log_pade_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_x_bits(s_x_bits),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_log_value(m_log_value),
        .m_invalid(m_invalid)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Pade (2,2) estimate of ln(m) plus e*ln2, rounded half up to FRAC_BITS.
    function automatic log_result_t predict_log(input logic [31:0] x);
        logic                  sign_bit;
        logic [EXP_BITS-1:0]   exp_field;
        logic [MANT_BITS-1:0]  frac;
        logic                  is_nan;
        longint unsigned       sig;
        longint unsigned       sq;
        longint unsigned       num;
        longint unsigned       den;
        longint unsigned       rem;
        longint unsigned       quo;
        longint signed         exp_unb;
        longint signed         sum;
        longint signed         rounded;
        log_result_t           r;
        sign_bit  = x[31];
        exp_field = x[30:MANT_BITS];
        frac      = x[MANT_BITS-1:0];
        is_nan    = (exp_field == '1) && (frac != '0);
        r.invalid = (sign_bit && !is_nan) || (x[30:0] == '0);
        r.value   = '0;
        if (!r.invalid) begin
            sig = (64'd1 << MANT_BITS) | longint'(frac);
            sq  = sig * sig;
            num = 3 * (sq - (64'd1 << (2 * MANT_BITS)));
            den = sq + (sig << (MANT_BITS + 2)) + (64'd1 << (2 * MANT_BITS));
            rem = num;
            quo = 0;
            for (int i = 0; i < QUOT_W; i++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    quo = quo | 64'd1;
                end
            end
            exp_unb = longint'(exp_field) - EXP_BIAS;
            sum     = longint'(quo) + exp_unb * longint'(LN2_Q32);
            // The arithmetic shift floors, so adding half an LSB rounds half up.
            rounded = (sum + (longint'(1) << (QUOT_W - FRAC_BITS - 1)))
                      >>> (QUOT_W - FRAC_BITS);
            r.value = rounded[OUT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] random_operand();
        int          pick;
        logic [31:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            v = {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
        end else if (pick < 65) begin
            v = $urandom;
        end else if (pick < 73) begin
            v = {1'b0, 8'($urandom_range(125, 128)), 23'($urandom)};
        end else if (pick < 80) begin
            v = {1'b0, 8'h00, 23'($urandom)};
        end else if (pick < 87) begin
            v = {1'($urandom), 8'hFF, 23'($urandom)};
            if ($urandom_range(0, 3) == 0) begin
                v[22:0] = '0;
            end
        end else if (pick < 95) begin
            v = {1'b1, 31'($urandom)};
        end else begin
            v = {1'($urandom), 8'($urandom), 23'h0};
            if ($urandom_range(0, 1) == 0) begin
                v[22:0] = '1;
            end else if ($urandom_range(0, 1) == 0) begin
                v[30:0] = '0;
            end
        end
        return v;
    endfunction

    task automatic wait_drained();
        while (operand_q.size() != 0 || s_valid || log_expect_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0 || operand_q.size() == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                s_valid <= 1'b0;
            end else begin
                s_valid  <= 1'b1;
                s_x_bits <= operand_q.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0, 1: gap_left = 0;
                        2: gap_left = $urandom_range(1, 3);
                        default: gap_left = $urandom_range(4, 40);
                    endcase
                end
            end
        end
    end

    // Receiver: switches between always ready, random, mostly stalled and mostly ready.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 4) == 0);
            default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge aclk) begin : result_check
        log_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                log_expect_q.push_back(predict_log(s_x_bits));
            end
            if (m_valid && m_ready) begin
                if (log_expect_q.size() == 0) begin
                    $display("%0t: unexpected result transfer: log_value=%h invalid=%b",
                             $time, m_log_value, m_invalid);
                    fail_count++;
                end else begin
                    want = log_expect_q.pop_front();
                    if (m_log_value !== want.value) begin
                        $display("%0t: log_value mismatch: expected %h, actual %h",
                                 $time, want.value, m_log_value);
                        fail_count++;
                    end
                    if (m_invalid !== want.invalid) begin
                        $display("%0t: invalid mismatch: expected %b, actual %b",
                                 $time, want.invalid, m_invalid);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("float_natural_log_pade_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Zeros, negatives, infinities, NaNs, subnormals and the mantissa extremes.
        operand_q.push_back(32'h0000_0000);
        operand_q.push_back(32'h8000_0000);
        operand_q.push_back(32'hBF80_0000);
        operand_q.push_back(32'hFF80_0000);
        operand_q.push_back(32'h8000_0001);
        operand_q.push_back(32'h807F_FFFF);
        operand_q.push_back(32'hFF7F_FFFF);
        operand_q.push_back(32'h7F80_0000);
        operand_q.push_back(32'h7FC0_0000);
        operand_q.push_back(32'h7F80_0001);
        operand_q.push_back(32'h7FFF_FFFF);
        operand_q.push_back(32'hFFC0_0000);
        operand_q.push_back(32'hFFFF_FFFF);
        operand_q.push_back(32'h0000_0001);
        operand_q.push_back(32'h007F_FFFF);
        operand_q.push_back(32'h0080_0000);
        operand_q.push_back(32'h3F80_0000);
        operand_q.push_back(32'h3FFF_FFFF);
        operand_q.push_back(32'h4000_0000);
        operand_q.push_back(32'h3F00_0000);
        operand_q.push_back(32'h7F7F_FFFF);
        operand_q.push_back(32'h3F7F_FFFF);
        operand_q.push_back(32'h5555_5555);
        operand_q.push_back(32'h2AAA_AAAA);
        @(negedge aclk);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            operand_q.push_back(random_operand());
            // Hold the sender off once midway so the pipeline runs empty.
            if (n == RANDOM_ITEMS / 2) begin
                wait_drained();
            end else if (operand_q.size() > 64) begin
                @(negedge aclk);
            end
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("float_natural_log_pade_unit regression: pass");
        end else begin
            $display("float_natural_log_pade_unit regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
